// File: src/signed_int_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii macros
// assertion helpers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define SIDASC_ASSERT_IMP(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define SIDASC_ASSERT_NXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: src/sidasc_pkg.sv
// ----------------------------------------------------------------------------
// sidasc_pkg
// shared constants and types of the signed integer to decimal text formatter
// ----------------------------------------------------------------------------
`default_nettype none

package sidasc_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int CHAR_BITS      = 6;
	localparam int DIGIT_BITS     = 4;

	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;

	typedef struct packed {
		logic clear;
		logic dabble;
		logic dshift;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: src/sidasc_cell.sv
// ----------------------------------------------------------------------------
// sidasc_cell
// one decimal digit of the chain: add-3 and bit shift while converting,
// whole digit shift toward the top while the text goes out
// ----------------------------------------------------------------------------
`default_nettype none

module sidasc_cell (
	input  wire logic                               clk,
	input  wire sidasc_pkg::cell_ctl_t              ctl,
	input  wire logic                               bit_in,
	input  wire logic [sidasc_pkg::DIGIT_BITS-1:0]  digit_in,
	output logic      [sidasc_pkg::DIGIT_BITS-1:0]  digit,
	output logic                                    carry
);

	logic [sidasc_pkg::DIGIT_BITS-1:0] digit_q;
	logic [sidasc_pkg::DIGIT_BITS-1:0] adj;

	// values of 5 and up overflow the digit after doubling
	assign adj   = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry = adj[sidasc_pkg::DIGIT_BITS-1];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[sidasc_pkg::DIGIT_BITS-2:0], bit_in};
		end else if (ctl.dshift) begin
			digit_q <= digit_in;
		end
	end

endmodule

`default_nettype wire

// File: src/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Formats a two's complement integer as decimal ASCII text.
// Input channel in_valid/in_ready carries value; each accepted item yields
// a '-' for negative values, then the digits of the magnitude, most
// significant first, without leading zeros ('0' alone for zero). The output
// channel out_valid/out_ready carries one character per item, last is set
// on the final character of the number.
// After acceptance the magnitude is shifted through a chain of decimal
// cells, one bit per cycle, then the chain shifts one digit position per
// cycle toward the output register while that register can take a
// character; leading zero positions are dropped at one per cycle.
// in_ready is high only while no conversion is running; the final character
// may still wait in the output register while the next value is taken.
// With a full output register and out_ready low, a due digit waits in the chain.
// Reset empties the output register and returns the block to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = sidasc_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [VALUE_BITS-1:0]        value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic        [sidasc_pkg::CHAR_BITS-1:0]  character,
	output logic                                     last
);

	localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int CNT_W  = $clog2(VALUE_BITS);
	localparam int REM_W  = $clog2(DIGITS + 1);
	localparam int DW     = sidasc_pkg::DIGIT_BITS;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [VALUE_BITS-1:0]          mag_q;
	logic                           neg_q;
	logic [CNT_W-1:0]               bit_cnt_q;
	logic [REM_W-1:0]               remaining_q;
	logic                           started_q;
	logic                           out_valid_q;
	logic [sidasc_pkg::CHAR_BITS-1:0] character_q;
	logic                           last_q;

	logic [VALUE_BITS-1:0]          raw;
	logic [VALUE_BITS-1:0]          mag_in;
	logic                           accept;
	logic                           slot_free;
	logic [DW-1:0]                  top;
	logic                           is_last;
	logic                           emit_now;
	logic                           advance;
	logic                           load_out;
	sidasc_pkg::cell_ctl_t          ctl;
	logic [DW-1:0]                  digit_w [DIGITS];
	logic                           carry_w [DIGITS];

	assign raw       = value;
	assign mag_in    = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + 1'b1) : raw;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign top       = digit_w[DIGITS-1];
	assign is_last   = (remaining_q == REM_W'(1));
	assign emit_now  = (top != '0) || started_q || is_last;
	assign advance   = (state_q == ST_EMIT) && (!emit_now || slot_free);
	assign load_out  = ((state_q == ST_SIGN) && slot_free) || (advance && emit_now);

	always_comb begin
		ctl.clear  = accept;
		ctl.dabble = (state_q == ST_CONV);
		ctl.dshift = advance;
	end

	// digit chain, least significant cell first
	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			sidasc_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.bit_in   (mag_q[VALUE_BITS-1]),
				.digit_in ('0),
				.digit    (digit_w[i]),
				.carry    (carry_w[i])
			);
		end else begin : g_next
			sidasc_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.bit_in   (carry_w[i-1]),
				.digit_in (digit_w[i-1]),
				.digit    (digit_w[i]),
				.carry    (carry_w[i])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
			neg_q <= raw[VALUE_BITS-1];
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			remaining_q <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == CNT_W'(VALUE_BITS - 1)) begin
						remaining_q <= REM_W'(DIGITS);
						started_q   <= 1'b0;
						state_q     <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (advance) begin
						remaining_q <= remaining_q - 1'b1;
						if (emit_now) begin
							started_q <= 1'b1;
						end
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_SIGN && slot_free) begin
			character_q <= sidasc_pkg::CHAR_MINUS;
			last_q      <= 1'b0;
		end else if (advance && emit_now) begin
			character_q <= sidasc_pkg::CHAR_ZERO + {2'b00, top};
			last_q      <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	`SIDASC_ASSERT_NXT(a_accept_starts_conv, accept, state_q == ST_CONV && !in_ready, "accepted item did not start conversion")
	`SIDASC_ASSERT_IMP(a_top_digit_decimal, state_q == ST_EMIT, top <= 4'd9, "digit chain holds a non-decimal digit")
	`SIDASC_ASSERT_IMP(a_minus_not_last, out_valid && character == sidasc_pkg::CHAR_MINUS, !last, "minus sign flagged as final character")
	`SIDASC_ASSERT_IMP(a_emit_has_positions, state_q == ST_EMIT, remaining_q != '0, "emission with no digit positions left")

endmodule

`default_nettype wire
